// File: rtl/ed_ed_run_length_decoder_macros.svh
// Assertion macros for the ED ED run-length decoder checker.
// Expects signals named clock and reset in the scope of use.
`ifndef ED_ED_RUN_LENGTH_DECODER_MACROS_SVH
`define ED_ED_RUN_LENGTH_DECODER_MACROS_SVH

// checked while out of reset
`define RLED_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define RLED_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/rled_pkg.sv
// Shared types and constants of the ED ED run-length decoder.
// No dependencies.
package rled_pkg;

   localparam int SizeW      = 17;
   localparam int ByteW      = 8;
   localparam int QueueDepth = 4;
   localparam int PtrW       = $clog2(QueueDepth);
   localparam int CountW     = $clog2(QueueDepth + 1);
   localparam int MaxPush    = 3;

   localparam logic [ByteW-1:0] EscapeByte = 8'd237;
   localparam logic [ByteW-1:0] PadByte    = 8'd0;
   localparam logic [SizeW-1:0] SizeReset  = 17'd16384;

   typedef struct packed {
      logic [ByteW-1:0] byte_value;
      logic [SizeW-1:0] run_length;
      logic             last_run;
   } run_type;

   typedef struct packed {
      logic [MaxPush-1:0]          en;
      run_type [MaxPush-1:0]       run;
   } push_type;

endpackage

// File: rtl/ed_ed_run_length_decoder.sv
// ED ED run-length decoder, top level.
// Depends on rled_pkg, rled_decode and rled_queue.
//
// Usage:
//   req_*  carries one compressed byte per item plus an end-of-input flag.
//   rsp_*  carries decoded runs (value, length); the run flagged last is the
//          zero padding that fills the block up to output_size.
//   csr_*  writes output_size; always ready, write only while idle.
// Both data channels move an item on an edge with valid high and stall low.
// An accepted item is registered, decoded into the result queue once the
// queue has room, and its first run is then shown at the queue head.
// Throughput: one item per cycle while items yield at most one run each and rsp_stall is low.
// An item can yield up to three runs; the four-entry result queue must have
// room for three before the registered item is decoded, so runs drain at
// one per cycle while rsp_stall is low and req_stall rises when the queue backs up.
// Reset (synchronous) empties the queue, clears the escape state and the
// byte count, and sets output_size to 16384.
// While rsp_stall is high the shown run holds; items are still decoded until
// fewer than three queue entries are free, then req_stall holds the sender.
module ed_ed_run_length_decoder import rled_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [ByteW-1:0] req_data_byte,
   input  logic             req_end_of_input,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [ByteW-1:0] rsp_byte_value,
   output logic [SizeW-1:0] rsp_run_length,
   output logic             rsp_last_run,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [SizeW-1:0] csr_output_size
);

   logic [SizeW-1:0] size_ff;
   push_type         push;
   logic             queue_room;
   run_type          out_run;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SizeReset;
      end else if (csr_valid && csr_ready) begin
         size_ff <= csr_output_size;
      end
   end

   rled_decode u_decode (
      .clock           (clock),
      .reset           (reset),
      .output_size     (size_ff),
      .in_valid        (req_valid),
      .in_data_byte    (req_data_byte),
      .in_end_of_input (req_end_of_input),
      .in_stall        (req_stall),
      .queue_room      (queue_room),
      .push            (push)
   );

   rled_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (queue_room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_run   (out_run)
   );

   assign rsp_byte_value = out_run.byte_value;
   assign rsp_run_length = out_run.run_length;
   assign rsp_last_run   = out_run.last_run;

endmodule

// File: rtl/rled_decode.sv
// Input register, escape state and run generation with clipping.
// Depends on rled_pkg.
module rled_decode import rled_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [SizeW-1:0] output_size,
   input  logic             in_valid,
   input  logic [ByteW-1:0] in_data_byte,
   input  logic             in_end_of_input,
   output logic             in_stall,
   input  logic             queue_room,
   output push_type         push
);

   typedef enum logic [1:0] {
      PH_NORMAL,
      PH_ONE_ESC,
      PH_TWO_ESC,
      PH_COUNT
   } phase_type;

   logic             in_valid_ff;
   logic [ByteW-1:0] data_ff;
   logic             eoi_ff;

   phase_type        phase_ff, phase_in;
   logic [ByteW-1:0] held_ff, held_in;
   logic [SizeW-1:0] produced_ff, produced_in;

   logic             advance;
   logic             load;
   logic [SizeW-1:0] room0, room1, room2;
   logic [SizeW-1:0] len_a, run_a, run_b;
   logic [ByteW-1:0] val_a;
   logic             want_b;

   assign advance  = in_valid_ff & queue_room;
   assign in_stall = in_valid_ff & ~queue_room;
   assign load     = in_valid & ~in_stall;

   always_comb begin
      room0    = (output_size > produced_ff) ? (output_size - produced_ff) : '0;
      len_a    = '0;
      val_a    = data_ff;
      want_b   = 1'b0;
      phase_in = phase_ff;
      held_in  = held_ff;
      if (room0 != '0) begin
         unique case (phase_ff)
            PH_NORMAL: begin
               if (data_ff != EscapeByte || eoi_ff) begin
                  len_a = SizeW'(1);
               end else begin
                  phase_in = PH_ONE_ESC;
               end
            end
            PH_ONE_ESC: begin
               if (data_ff != EscapeByte) begin
                  val_a    = EscapeByte;
                  len_a    = SizeW'(1);
                  want_b   = 1'b1;
                  phase_in = PH_NORMAL;
               end else begin
                  phase_in = PH_TWO_ESC;
               end
            end
            PH_TWO_ESC: begin
               held_in  = data_ff;
               phase_in = PH_COUNT;
            end
            PH_COUNT: begin
               len_a    = {{(SizeW-ByteW){1'b0}}, held_ff};
               phase_in = PH_NORMAL;
            end
            default: phase_in = PH_NORMAL;
         endcase
      end
      run_a       = (len_a > room0) ? room0 : len_a;
      room1       = room0 - run_a;
      run_b       = (want_b && room1 != '0) ? SizeW'(1) : '0;
      room2       = room1 - run_b;
      produced_in = produced_ff + run_a + run_b;
      if (eoi_ff) begin
         phase_in    = PH_NORMAL;
         held_in     = '0;
         produced_in = '0;
      end

      push.en[0]  = advance && (run_a != '0);
      push.run[0] = '{byte_value: val_a, run_length: run_a, last_run: 1'b0};
      push.en[1]  = advance && (run_b != '0);
      push.run[1] = '{byte_value: data_ff, run_length: run_b, last_run: 1'b0};
      push.en[2]  = advance && eoi_ff;
      push.run[2] = '{byte_value: PadByte, run_length: room2, last_run: 1'b1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_NORMAL;
         held_ff     <= '0;
         produced_ff <= '0;
      end else begin
         if (load) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            phase_ff    <= phase_in;
            held_ff     <= held_in;
            produced_ff <= produced_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= in_data_byte;
         eoi_ff  <= in_end_of_input;
      end
   end

endmodule

// File: rtl/rled_queue.sv
// Result queue: takes up to three runs a cycle, hands out one while out_stall is low.
// Depends on rled_pkg.
module rled_queue import rled_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output logic     out_valid,
   input  logic     out_stall,
   output run_type  out_run
);

   run_type           q_ff [QueueDepth];
   logic [PtrW-1:0]   wptr_ff, wptr_in;
   logic [PtrW-1:0]   rptr_ff, rptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [CountW-1:0] after_pop;
   logic [CountW-1:0] n_push;
   logic [PtrW-1:0]   pos [MaxPush];
   logic              pop;

   assign out_valid = (count_ff != '0);
   assign out_run   = q_ff[rptr_ff];
   assign pop       = out_valid & ~out_stall;
   assign after_pop = count_ff - CountW'(pop);
   assign room      = (after_pop <= CountW'(QueueDepth - MaxPush));

   always_comb begin
      pos[0]   = '0;
      pos[1]   = PtrW'(push.en[0]);
      pos[2]   = PtrW'(push.en[0]) + PtrW'(push.en[1]);
      n_push   = CountW'(push.en[0]) + CountW'(push.en[1]) + CountW'(push.en[2]);
      wptr_in  = wptr_ff + PtrW'(n_push);
      rptr_in  = rptr_ff + PtrW'(pop);
      count_in = after_pop + n_push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MaxPush; i++) begin
         if (push.en[i]) begin
            q_ff[wptr_ff + pos[i]] <= push.run[i];
         end
      end
   end

endmodule

// File: rtl/rled_checker.sv
// Port-level checks for the ED ED run-length decoder, bound to the top level.
// Depends on rled_pkg and ed_ed_run_length_decoder_macros.svh.
`include "ed_ed_run_length_decoder_macros.svh"

module rled_checker import rled_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [ByteW-1:0] rsp_byte_value,
   input logic [SizeW-1:0] rsp_run_length,
   input logic             rsp_last_run
);

   run_type rsp_run;
   logic    rsp_held;
   logic    rsp_empty_run;

   assign rsp_run       = {rsp_byte_value, rsp_run_length, rsp_last_run};
   assign rsp_held      = rsp_valid && rsp_stall;
   assign rsp_empty_run = rsp_valid && (rsp_run_length == '0);

   `RLED_ASSERT_ALWAYS(a_reset_empty, reset |=> (!rsp_valid && !req_stall), "not empty after reset")

   `RLED_ASSERT(a_rsp_hold, rsp_held |=> (rsp_valid && $stable(rsp_run)), "stalled item changed")

   `RLED_ASSERT(a_zero_only_last, rsp_empty_run |-> rsp_last_run, "empty run not last")

   `RLED_ASSERT(a_empty_no_stall, !rsp_valid |-> !req_stall, "stall with empty queue")

endmodule

bind ed_ed_run_length_decoder rled_checker u_rled_checker (.*);
